FILE: hw/rtl/twr_pkg.sv
`timescale 1ns / 1ps

package twr_pkg;

    // one raw measurement set of the ranging exchange
    typedef struct packed {
        logic [15:0] resp_time;
        logic [15:0] toa_ack;
        logic [15:0] toa_data;
        logic [2:0]  phase_ack;
        logic [2:0]  phase_data;
    } t_set_meas;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISAGREE = 2'd1,
        ST_NEG_AVG  = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_OFFSET = 2'd0,
        CFG_SINGLE_SET   = 2'd1,
        CFG_MAX_DISAGREE = 2'd2
    } t_cfg_idx;

    // pipeline depths
    localparam int SET_LAT = 10;
    localparam int OUT_LAT = SET_LAT + 3;

    // width of a per-set distance, signed Q.12 metres
    localparam int DIST_W = 39;

    // toa term: toa = 2*x + floor((x*13868 + 29301) / 58602), x = 5*(ack + data)
    localparam logic [2:0]  TOA_SCALE    = 3'd5;
    localparam logic [13:0] TOA_FRAC_MUL = 14'd13868;
    localparam logic [14:0] TOA_ROUND    = 15'd29301;
    localparam logic [15:0] TOA_DIV      = 16'd58602;
    localparam logic [17:0] TOA_DIV2     = 18'd117204;
    localparam logic [24:0] TOA_RECIP    = 25'((64'd1 << 40) / 64'd58602);

    // light speed factor: d = floor((t*K + 8e6) / 16e6)
    localparam logic [27:0] LIGHT_K   = 28'd149896229;
    localparam logic [63:0] DIST_BIAS = 64'd8000000 + (64'd16000000 << 38);
    localparam logic [13:0] DIST_DIV  = 14'd15625;
    localparam logic [15:0] DIST_DIV2 = 16'd31250;
    localparam logic [46:0] DIST_RECIP = 47'((64'd1 << 60) / 64'd15625);

    // exact floor(y/3) for y below 2^21 as (y*R) >> 23
    localparam logic [21:0] DIV3_RECIP = 22'(((64'd1 << 23) + 64'd1) / 64'd3);

    localparam logic [7:0] MAXDIS_RST = 8'd6;

    // phase offset to gate ticks: seven stays, others are six minus value
    function automatic logic [2:0] phase_map(input logic [2:0] v);
        return (v == 3'd7) ? 3'd7 : 3'd6 - v;
    endfunction

endpackage

FILE: hw/rtl/two_way_ranging_distance_core.sv
`timescale 1ns / 1ps

// Double-sided two-way ranging distance core.
// Command channel: a beat of two raw measurement sets is taken on each rising
// edge with start high and busy low. busy is high only in reset and until the
// first clock edge after it; otherwise a new beat can enter every cycle.
// Result channel: o_strobe is high for one cycle with o_distance (unsigned
// Q20.12 metres, saturating) and o_status (0 ok, 1 sets disagree, 2 average
// at or below -1 m, 3 ranging disabled; distance is zero unless ok).
// Between accept and strobe lie ten stages per set (toa reciprocal divide,
// air time, light-speed product, reciprocal divide by the time base) and
// then three stages for agreement check, means and clamping.
// Throughput is one beat per cycle; results leave in the order taken.
// The result side has no stall; the receiver must take each strobe.
// Configuration: write enable, index and data; range offset (index 0),
// single set mode (index 1), max disagreement (index 2). Write only while no
// beat is in flight. Reset (synchronous, active low) clears the pipeline and
// sets range offset 0, single set mode off, max disagreement 6 m.
module two_way_ranging_distance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic [15:0] i_resp_time_a,
    input  logic [15:0] i_toa_ack_a,
    input  logic [15:0] i_toa_data_a,
    input  logic [2:0]  i_phase_ack_a,
    input  logic [2:0]  i_phase_data_a,
    input  logic [15:0] i_resp_time_b,
    input  logic [15:0] i_toa_ack_b,
    input  logic [15:0] i_toa_data_b,
    input  logic [2:0]  i_phase_ack_b,
    input  logic [2:0]  i_phase_data_b,
    output logic        o_strobe,
    output logic [31:0] o_distance,
    output logic [1:0]  o_status
);
    import twr_pkg::*;

    localparam logic signed [39:0] NEG_AVG_LIM = -40'sd8192;
    localparam logic signed [39:0] WMEAN_LIM   = 40'sd16384;

    logic               r_busy;
    logic               w_accept;
    logic signed [31:0] r_range_offset;
    logic               r_single;
    logic [7:0]         r_max_dis;

    t_set_meas w_meas_a;
    t_set_meas w_meas_b;
    logic      w_vld_a;
    logic      w_vld_b;
    logic signed [DIST_W-1:0] w_d1;
    logic signed [DIST_W-1:0] w_d2;

    // combine stage 1
    logic                     w_a_gt;
    logic [39:0]              w_diff;
    logic signed [39:0]       w_sum;
    logic                     r_vld1;
    logic signed [DIST_W-1:0] r_small1;
    logic [39:0]              r_diff1;
    logic signed [39:0]       r_sum1;
    logic signed [DIST_W-1:0] r_d1_1;

    // combine stage 2
    logic                     w_disagree;
    logic [20:0]              w_y;
    logic [42:0]              w_third;
    logic signed [39:0]       w_wmean;
    logic signed [39:0]       w_avg;
    logic                     r_vld2;
    logic                     r_dis2;
    logic signed [39:0]       r_sum2;
    logic signed [39:0]       r_wmean2;
    logic signed [39:0]       r_avg2;
    logic signed [DIST_W-1:0] r_d1_2;

    // output registers
    logic        r_strobe;
    logic [31:0] r_dist;
    t_status     r_status;

    function automatic logic [31:0] sat_dist(input logic signed [39:0] v);
        logic [31:0] res;
        if (v[39]) begin
            res = '0;
        end else if (|v[38:32]) begin
            res = '1;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // busy only around reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_offset <= '0;
            r_single       <= 1'b0;
            r_max_dis      <= MAXDIS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_OFFSET: r_range_offset <= i_cfg_wdata;
                CFG_SINGLE_SET:   r_single       <= i_cfg_wdata[0];
                CFG_MAX_DISAGREE: r_max_dis      <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // per-set distance pipelines
    assign w_meas_a = '{resp_time: i_resp_time_a, toa_ack: i_toa_ack_a,
                        toa_data: i_toa_data_a, phase_ack: i_phase_ack_a,
                        phase_data: i_phase_data_a};
    assign w_meas_b = '{resp_time: i_resp_time_b, toa_ack: i_toa_ack_b,
                        toa_data: i_toa_data_b, phase_ack: i_phase_ack_b,
                        phase_data: i_phase_data_b};

    twr_set_dist u_set_a (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_meas         (w_meas_a),
        .i_range_offset (r_range_offset),
        .o_valid        (w_vld_a),
        .o_dist         (w_d1)
    );

    twr_set_dist u_set_b (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_meas         (w_meas_b),
        .i_range_offset (r_range_offset),
        .o_valid        (w_vld_b),
        .o_dist         (w_d2)
    );

    // combine stage 1: difference, sum, smaller set
    assign w_a_gt = w_d1 > w_d2;
    assign w_diff = w_a_gt ? 40'(w_d1) - 40'(w_d2) : 40'(w_d2) - 40'(w_d1);
    assign w_sum  = 40'(w_d1) + 40'(w_d2);

    always_ff @(posedge i_clk) begin
        if (w_vld_a) begin
            r_small1 <= w_a_gt ? w_d2 : w_d1;
            r_diff1  <= w_diff;
            r_sum1   <= w_sum;
            r_d1_1   <= w_d1;
        end
    end

    // combine stage 2: agreement check, weighted mean, plain mean
    assign w_disagree = r_diff1 > {20'b0, r_max_dis, 12'b0};
    assign w_y        = 21'(r_diff1[19:0]) + 21'd1;
    assign w_third    = 43'(w_y) * 43'(DIV3_RECIP);
    assign w_wmean    = 40'(r_small1) + $signed({21'b0, w_third[41:23]});
    assign w_avg      = (r_sum1 + 40'sd1) >>> 1;

    always_ff @(posedge i_clk) begin
        if (r_vld1) begin
            r_dis2   <= w_disagree;
            r_sum2   <= r_sum1;
            r_wmean2 <= w_wmean;
            r_avg2   <= w_avg;
            r_d1_2   <= r_d1_1;
        end
    end

    // combine stage 3: pick the result and clamp
    always_ff @(posedge i_clk) begin
        if (r_vld2) begin
            priority if (r_range_offset == '0) begin
                r_status <= ST_DISABLED;
                r_dist   <= '0;
            end else if (r_single) begin
                r_status <= ST_OK;
                r_dist   <= sat_dist(40'(r_d1_2));
            end else if (r_dis2) begin
                r_status <= ST_DISAGREE;
                r_dist   <= '0;
            end else if (r_sum2 < 40'sd0) begin
                r_status <= (r_sum2 <= NEG_AVG_LIM) ? ST_NEG_AVG : ST_OK;
                r_dist   <= '0;
            end else if (r_sum2 > WMEAN_LIM) begin
                r_status <= ST_OK;
                r_dist   <= sat_dist(r_wmean2);
            end else begin
                r_status <= ST_OK;
                r_dist   <= sat_dist(r_avg2);
            end
        end
    end

    // combine valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1   <= 1'b0;
            r_vld2   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld1   <= w_vld_a;
            r_vld2   <= r_vld1;
            r_strobe <= r_vld2;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_distance = r_dist;
    assign o_status   = r_status;

`ifndef SYNTHESIS
    // both set pipelines carry the same beats
    a_sets_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld_a == w_vld_b)
        else $error("set pipelines out of step");

    // every accepted beat is followed by a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##OUT_LAT o_strobe)
        else $error("result missing after accepted beat");

    // a failed measurement reports zero distance
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |-> (o_distance == '0))
        else $error("nonzero distance with failing status");

    // disabled status exactly when the calibration offset is zero
    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_status == ST_DISABLED) == (r_range_offset == '0)))
        else $error("disabled status does not match range offset");
`endif

endmodule

FILE: hw/rtl/twr_set_dist.sv
`timescale 1ns / 1ps

module twr_set_dist (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  twr_pkg::t_set_meas     i_meas,
    input  logic signed [31:0]     i_range_offset,
    output logic                   o_valid,
    output logic signed [twr_pkg::DIST_W-1:0] o_dist
);
    import twr_pkg::*;

    logic [SET_LAT-1:0] r_vld;

    // stage 1 signals
    logic [16:0] w_usum;
    logic [19:0] w_x;
    logic [33:0] w_z;
    logic [3:0]  w_gate;
    logic [31:0] w_base;
    logic [19:0] r_x1;
    logic [33:0] r_z1;
    logic [31:0] r_base1;

    // stage 2 signals
    logic [47:0] w_prod2;
    logic [17:0] r_q2;
    logic [17:0] r_zl2;
    logic [19:0] r_x2;
    logic [31:0] r_base2;

    // stage 3 signals
    logic [17:0] w_mul3;
    logic [17:0] r_q3;
    logic [17:0] r_rem3;
    logic [19:0] r_x3;
    logic [31:0] r_base3;

    // stage 4 signals
    logic [1:0]  w_inc4;
    logic [20:0] w_toa4;
    logic [33:0] w_t4;
    logic [33:0] r_t4;

    // stage 5 signals
    logic signed [45:0] w_thk5;
    logic [44:0]        w_tlk5;
    logic signed [45:0] r_thk5;
    logic [44:0]        r_tlk5;

    // stage 6 signals
    logic [63:0] w_u6;
    logic [52:0] r_v6;

    // stage 7..9 signals
    logic [39:0] w_vh7;
    logic [43:0] r_p00;
    logic [42:0] r_p01;
    logic [43:0] r_p10;
    logic [42:0] r_p11;
    logic [15:0] r_vl7;
    logic [47:0] r_mid8;
    logic [43:0] r_lo8;
    logic [42:0] r_hi8;
    logic [15:0] r_vl8;
    logic [85:0] w_full9;
    logic [38:0] r_q9;
    logic [15:0] r_vl9;

    // stage 10 signals
    logic [15:0] w_mul10;
    logic [15:0] w_rem10;
    logic [1:0]  w_inc10;
    logic [38:0] w_qc10;
    logic signed [DIST_W-1:0] r_d10;

    // valid bits travel with the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SET_LAT-2:0], i_valid};
        end
    end

    // stage 1: toa numerator and response minus gate term
    assign w_usum = {1'b0, i_meas.toa_ack} + {1'b0, i_meas.toa_data};
    assign w_x    = 20'(w_usum) * 20'(TOA_SCALE);
    assign w_z    = 34'(w_x) * 34'(TOA_FRAC_MUL) + 34'(TOA_ROUND);
    assign w_gate = {1'b0, phase_map(i_meas.phase_ack)}
                  + {1'b0, phase_map(i_meas.phase_data)};
    assign w_base = {2'b0, i_meas.resp_time, 14'b0} - {17'b0, w_gate, 11'b0};

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_x1    <= w_x;
            r_z1    <= w_z;
            r_base1 <= w_base;
        end
    end

    // stage 2: reciprocal estimate of the toa quotient, never high
    assign w_prod2 = 48'(r_z1[33:10]) * 48'(TOA_RECIP);

    always_ff @(posedge i_clk) begin
        if (r_vld[0]) begin
            r_q2    <= w_prod2[47:30];
            r_zl2   <= r_z1[17:0];
            r_x2    <= r_x1;
            r_base2 <= r_base1;
        end
    end

    // stage 3: remainder of the estimate, low bits only
    assign w_mul3 = r_q2 * 18'(TOA_DIV);

    always_ff @(posedge i_clk) begin
        if (r_vld[1]) begin
            r_q3    <= r_q2;
            r_rem3  <= r_zl2 - w_mul3;
            r_x3    <= r_x2;
            r_base3 <= r_base2;
        end
    end

    // stage 4: quotient correction, air time minus twice the calibration
    always_comb begin
        if (r_rem3 >= TOA_DIV2) begin
            w_inc4 = 2'd2;
        end else if (r_rem3 >= 18'(TOA_DIV)) begin
            w_inc4 = 2'd1;
        end else begin
            w_inc4 = 2'd0;
        end
    end

    assign w_toa4 = {r_x3, 1'b0} + 21'(r_q3) + 21'(w_inc4);
    assign w_t4   = {{2{r_base3[31]}}, r_base3} - 34'(w_toa4)
                  - {i_range_offset[31], i_range_offset, 1'b0};

    always_ff @(posedge i_clk) begin
        if (r_vld[2]) begin
            r_t4 <= w_t4;
        end
    end

    // stage 5: time times light factor as two partial products
    assign w_thk5 = $signed(r_t4[33:17]) * $signed({1'b0, LIGHT_K});
    assign w_tlk5 = 45'(r_t4[16:0]) * 45'(LIGHT_K);

    always_ff @(posedge i_clk) begin
        if (r_vld[3]) begin
            r_thk5 <= w_thk5;
            r_tlk5 <= w_tlk5;
        end
    end

    // stage 6: full product plus rounding and bias, then drop the power of two
    assign w_u6 = ({{18{r_thk5[45]}}, r_thk5} << 17) + 64'(r_tlk5) + DIST_BIAS;

    always_ff @(posedge i_clk) begin
        if (r_vld[4]) begin
            r_v6 <= w_u6[62:10];
        end
    end

    // stage 7: reciprocal partial products for the divide by 15625
    assign w_vh7 = r_v6[52:13];

    always_ff @(posedge i_clk) begin
        if (r_vld[5]) begin
            r_p00 <= 44'(w_vh7[19:0])  * 44'(DIST_RECIP[23:0]);
            r_p01 <= 43'(w_vh7[19:0])  * 43'(DIST_RECIP[46:24]);
            r_p10 <= 44'(w_vh7[39:20]) * 44'(DIST_RECIP[23:0]);
            r_p11 <= 43'(w_vh7[39:20]) * 43'(DIST_RECIP[46:24]);
            r_vl7 <= r_v6[15:0];
        end
    end

    // stage 8: fold the cross terms, low-by-high sits four bits above high-by-low
    always_ff @(posedge i_clk) begin
        if (r_vld[6]) begin
            r_mid8 <= {1'b0, r_p01, 4'b0} + 48'(r_p10);
            r_lo8  <= r_p00;
            r_hi8  <= r_p11;
            r_vl8  <= r_vl7;
        end
    end

    // stage 9: quotient estimate, at most one low
    assign w_full9 = (86'(r_hi8) << 44) + (86'(r_mid8) << 20) + 86'(r_lo8);

    always_ff @(posedge i_clk) begin
        if (r_vld[7]) begin
            r_q9  <= w_full9[85:47];
            r_vl9 <= r_vl8;
        end
    end

    // stage 10: remainder check, then remove the bias by flipping the top bit
    assign w_mul10 = r_q9[15:0] * 16'(DIST_DIV);
    assign w_rem10 = r_vl9 - w_mul10;

    always_comb begin
        if (w_rem10 >= DIST_DIV2) begin
            w_inc10 = 2'd2;
        end else if (w_rem10 >= 16'(DIST_DIV)) begin
            w_inc10 = 2'd1;
        end else begin
            w_inc10 = 2'd0;
        end
    end

    assign w_qc10 = r_q9 + 39'(w_inc10);

    always_ff @(posedge i_clk) begin
        if (r_vld[8]) begin
            r_d10 <= {~w_qc10[38], w_qc10[37:0]};
        end
    end

    assign o_valid = r_vld[SET_LAT-1];
    assign o_dist  = r_d10;

endmodule

FILE: tb/two_way_ranging_distance_core_test.sv
`timescale 1ns / 1ps

module two_way_ranging_distance_core_test;

    import twr_pkg::*;

    localparam longint Q_METRE = 4096;

    // one result beat as the block should deliver it
    typedef struct {
        logic [31:0] distance;
        t_status     status;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_RANGE_OFFSET;
    logic [31:0] i_cfg_wdata = '0;
    logic [15:0] i_resp_time_a = '0;
    logic [15:0] i_toa_ack_a = '0;
    logic [15:0] i_toa_data_a = '0;
    logic [2:0]  i_phase_ack_a = '0;
    logic [2:0]  i_phase_data_a = '0;
    logic [15:0] i_resp_time_b = '0;
    logic [15:0] i_toa_ack_b = '0;
    logic [15:0] i_toa_data_b = '0;
    logic [2:0]  i_phase_ack_b = '0;
    logic [2:0]  i_phase_data_b = '0;
    logic        o_strobe;
    logic [31:0] o_distance;
    logic [1:0]  o_status;

    // register shadow, reset values
    logic signed [31:0] cfg_offset = '0;
    logic               cfg_single = 1'b0;
    logic [7:0]         cfg_maxdis = MAXDIS_RST;

    t_reading pending_ranges[$];
    t_reading want;
    int       errors = 0;
    int       beats_taken = 0;
    int       settings_used = 0;
    int       status_seen[4] = '{0, 0, 0, 0};
    bit       gaps_on = 1'b1;

    two_way_ranging_distance_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_resp_time_a  (i_resp_time_a),
        .i_toa_ack_a    (i_toa_ack_a),
        .i_toa_data_a   (i_toa_data_a),
        .i_phase_ack_a  (i_phase_ack_a),
        .i_phase_data_a (i_phase_data_a),
        .i_resp_time_b  (i_resp_time_b),
        .i_toa_ack_b    (i_toa_ack_b),
        .i_toa_data_b   (i_toa_data_b),
        .i_phase_ack_b  (i_phase_ack_b),
        .i_phase_data_b (i_phase_data_b),
        .o_strobe       (o_strobe),
        .o_distance     (o_distance),
        .o_status       (o_status)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // floor division, divisor positive
    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    // round half up, divisor positive
    function automatic longint div_round(longint n, longint d);
        return div_floor(2 * n + d, 2 * d);
    endfunction

    function automatic longint gate_ticks(logic [2:0] v);
        return (v == 3'd7) ? longint'(7) : longint'(6) - longint'(v);
    endfunction

    // air time of one set before halving, q16.16 us
    function automatic longint air_time(t_set_meas s);
        longint toa;
        longint gate;
        toa  = div_round((longint'(s.toa_ack) + longint'(s.toa_data)) * 327680, 29301);
        gate = gate_ticks(s.phase_ack) + gate_ticks(s.phase_data);
        return longint'(s.resp_time) * 16384 - gate * 2048 - toa;
    endfunction

    // signed q.12 metres of one set under the current offset
    function automatic longint set_distance(t_set_meas s);
        longint t;
        t = air_time(s) - 2 * longint'(cfg_offset);
        return div_round(t * 149896229, 16000000);
    endfunction

    function automatic logic [31:0] clamp_dist(longint d);
        if (d < 0)
            return '0;
        if (d > longint'(32'hFFFF_FFFF))
            return 32'hFFFF_FFFF;
        return d[31:0];
    endfunction

    // expected reading for one pair of sets
    function automatic t_reading predict_range(t_set_meas a, t_set_meas b);
        t_reading r;
        longint   d1;
        longint   d2;
        longint   gap;
        longint   sum;
        longint   mean;
        r.distance = '0;
        r.status   = ST_OK;
        if (cfg_offset == 0) begin
            r.status = ST_DISABLED;
        end else if (cfg_single) begin
            r.distance = clamp_dist(set_distance(a));
        end else begin
            d1  = set_distance(a);
            d2  = set_distance(b);
            gap = (d1 > d2) ? d1 - d2 : d2 - d1;
            sum = d1 + d2;
            if (gap > longint'(cfg_maxdis) * Q_METRE) begin
                r.status = ST_DISAGREE;
            end else if (sum < 0) begin
                if (sum <= -2 * Q_METRE)
                    r.status = ST_NEG_AVG;
            end else if (sum > 4 * Q_METRE) begin
                mean = (d1 > d2) ? div_round(d1 + 2 * d2, 3) : div_round(2 * d1 + d2, 3);
                r.distance = clamp_dist(mean);
            end else begin
                r.distance = clamp_dist(div_round(sum, 2));
            end
        end
        return r;
    endfunction

    // offset that puts set s near the given distance in metres
    function automatic logic [31:0] offset_for(t_set_meas s, int metres);
        longint t_goal;
        longint ofs;
        t_goal = longint'(metres) * Q_METRE * 16000000 / 149896229;
        ofs = (air_time(s) - t_goal) / 2;
        if (ofs == 0)
            ofs = 1;
        return ofs[31:0];
    endfunction

    function automatic t_set_meas rand_set();
        t_set_meas s;
        s.resp_time  = 16'($urandom);
        s.toa_ack    = 16'($urandom);
        s.toa_data   = 16'($urandom);
        s.phase_ack  = 3'($urandom);
        s.phase_data = 3'($urandom);
        return s;
    endfunction

    // fixed set whose data toa mean is shifted by k; larger k is shorter
    function automatic t_set_meas anchor_set(int k);
        t_set_meas s;
        s.resp_time  = 16'd1000;
        s.toa_ack    = 16'd1000;
        s.toa_data   = 16'(1000 + k);
        s.phase_ack  = 3'd3;
        s.phase_data = 3'd3;
        return s;
    endfunction

    function automatic logic [15:0] nudge(logic [15:0] v, int span);
        int x;
        x = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (x < 0)
            x = 0;
        if (x > 65535)
            x = 65535;
        return 16'(x);
    endfunction

    // result checker: one strobe, one beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_ranges.size() == 0) begin
                $error("unexpected result beat: o_distance %0d o_status %0d",
                       o_distance, o_status);
                errors++;
            end else begin
                want = pending_ranges.pop_front();
                status_seen[o_status]++;
                if (o_distance !== want.distance) begin
                    $error("o_distance mismatch: expected %0d, actual %0d",
                           want.distance, o_distance);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("o_status mismatch: expected %0d, actual %0d",
                           want.status, o_status);
                    errors++;
                end
            end
        end
    end

    // one command beat, with random idle cycles in front while gaps are on
    task automatic send_beat(t_set_meas a, t_set_meas b);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 28) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_resp_time_a  <= a.resp_time;
        i_toa_ack_a    <= a.toa_ack;
        i_toa_data_a   <= a.toa_data;
        i_phase_ack_a  <= a.phase_ack;
        i_phase_data_a <= a.phase_data;
        i_resp_time_b  <= b.resp_time;
        i_toa_ack_b    <= b.toa_ack;
        i_toa_data_b   <= b.toa_data;
        i_phase_ack_b  <= b.phase_ack;
        i_phase_data_b <= b.phase_data;
        start          <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_ranges.push_back(predict_range(a, b));
        beats_taken++;
    endtask

    // drain the pipeline
    task automatic settle();
        start <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // register writes, only with nothing in flight
    task automatic configure(logic [31:0] ofs, logic [31:0] single_word,
                             logic [31:0] maxdis_word, bit offset_only);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RANGE_OFFSET;
        i_cfg_wdata <= ofs;
        @(posedge i_clk);
        if (!offset_only) begin
            i_cfg_idx   <= CFG_SINGLE_SET;
            i_cfg_wdata <= single_word;
            @(posedge i_clk);
            i_cfg_idx   <= CFG_MAX_DISAGREE;
            i_cfg_wdata <= maxdis_word;
            @(posedge i_clk);
            cfg_single = single_word[0];
            cfg_maxdis = maxdis_word[7:0];
        end
        i_cfg_we <= 1'b0;
        cfg_offset = ofs;
        settings_used++;
    endtask

    // zero offset out of reset means ranging is off
    task automatic test_disabled_after_reset();
        send_beat('0, '0);
        send_beat('1, '1);
    endtask

    // offset extremes: far negative distances and saturation
    task automatic test_offset_extremes();
        configure(32'h7FFF_FFFF, '0, '0, 1'b1);
        send_beat('0, '0);
        send_beat('1, '1);
        send_beat('0, '1);
        configure(32'h8000_0000, '0, '0, 1'b1);
        send_beat('0, '0);
        send_beat('1, '1);
        send_beat('1, '0);
    endtask

    // every phase code in every phase field
    task automatic test_phase_mapping();
        t_set_meas s;
        configure(offset_for(anchor_set(0), 20), 32'd1, 32'd6, 1'b0);
        for (int i = 0; i < 8; i++) begin
            s = anchor_set(0);
            s.phase_ack  = 3'(i);
            s.phase_data = 3'(i + 3);
            send_beat(s, s);
        end
    endtask

    // clamping, averaging and agreement corners
    task automatic test_special_cases();
        logic [31:0] ofs;
        ofs = offset_for(anchor_set(0), 0);
        // single set below zero
        configure(ofs, 32'd1, 32'd6, 1'b0);
        send_beat(anchor_set(100), rand_set());
        // both sets
        configure(ofs, 32'd0, 32'd6, 1'b0);
        send_beat(anchor_set(20), anchor_set(20));
        send_beat(anchor_set(120), anchor_set(120));
        send_beat(anchor_set(-40), anchor_set(-40));
        send_beat(anchor_set(-400), anchor_set(-380));
        send_beat(anchor_set(0), anchor_set(-400));
        // weighted mean pulled below zero
        configure(ofs, 32'd0, 32'd255, 1'b0);
        send_beat(anchor_set(-2000), anchor_set(1600));
        // no slack at all
        configure(ofs, 32'd0, 32'd0, 1'b0);
        send_beat(anchor_set(0), anchor_set(1));
    endtask

    // random settings with mostly plausible measurement pairs
    task automatic test_random_traffic();
        t_set_meas   base;
        t_set_meas   a;
        t_set_meas   b;
        logic [31:0] ofs;
        logic [7:0]  md;
        int          pick;
        for (int ph = 0; ph < 12; ph++) begin
            base = rand_set();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                ofs = '0;
            else if (pick < 15)
                ofs = $urandom;
            else
                ofs = offset_for(base, int'($urandom_range(0, 80)) - 20);
            case ($urandom_range(0, 3))
                0: md = 8'd0;
                1: md = 8'd255;
                2: md = MAXDIS_RST;
                default: md = 8'($urandom);
            endcase
            configure(ofs, {31'($urandom), 1'($urandom_range(0, 3) == 0)},
                      {24'($urandom), md}, 1'b0);
            gaps_on = (ph != 5);
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_beat(rand_set(), rand_set());
                end else begin
                    a = base;
                    a.toa_ack    = nudge(base.toa_ack, 1500);
                    a.toa_data   = nudge(base.toa_data, 1500);
                    a.phase_ack  = 3'($urandom);
                    a.phase_data = 3'($urandom);
                    if ($urandom_range(0, 19) == 0)
                        a.resp_time = a.resp_time + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
                    b = a;
                    b.toa_ack  = nudge(a.toa_ack, 60);
                    b.toa_data = nudge(a.toa_data, 60);
                    if ($urandom_range(0, 9) < 3)
                        b.phase_ack = 3'($urandom);
                    if ($urandom_range(0, 9) < 3)
                        b.phase_data = 3'($urandom);
                    send_beat(a, b);
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_offset_extremes();
        test_phase_mapping();
        test_special_cases();
        test_random_traffic();
        settle();
        repeat (OUT_LAT + 4) @(posedge i_clk);
        $display("checked %0d ranging beats over %0d register settings", beats_taken,
                 settings_used);
        $display("results by status: ok %0d, disagree %0d, negative %0d, disabled %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && pending_ranges.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (pending_ranges.size() != 0)
                $error("%0d expected results never arrived", pending_ranges.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
